// ===== sv/adjs_pkg.sv =====
// Shared types, constants and helper functions for the mesh edge adjacency scan.
// No dependencies; every other RTL file of the block but adjs_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package adjs_pkg;

    localparam int MAX_VERTS  = 64;
    localparam int MAX_FACES  = 16;
    localparam int VADDR_W    = $clog2(MAX_VERTS);
    localparam int FADDR_W    = $clog2(MAX_FACES);

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 6;
    localparam int COORD_W    = 24;
    localparam int CORNER_W   = 7;
    localparam int EDGE_W     = 2;
    localparam int CNT_W      = 5;
    localparam int EPS_W      = 24;
    localparam int OFACE_W    = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int FACE_W     = 4 * CORNER_W;
    localparam int VTX_W      = 3 * COORD_W;
    localparam int VEC_W      = COORD_W + 1;

    // Operands of the shared multiplier are kept as 55-bit signed values,
    // their magnitudes fit in 54 bits, split into two 27-bit halves.
    localparam int OPND_W     = 55;
    localparam int MAG_W      = 54;
    localparam int HALF_W     = 27;
    localparam int ACC_W      = 110;
    localparam int MAC_STEPS  = 4;

    localparam logic [CORNER_W-1:0] ABSENT_CORNER = CORNER_W'(64);

    localparam logic [OP_W-1:0] OP_VERTEX = 2'd0;
    localparam logic [OP_W-1:0] OP_FACE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_EPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_EPS   = 2'd2;

    typedef struct packed {
        logic             start;
        logic             clr;
        logic             neg;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
    } t_mac_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } t_mac_rsp;

    // Corner k of a packed face word.
    function automatic logic [CORNER_W-1:0] corner_at(input logic [FACE_W-1:0] w,
                                                      input logic [EDGE_W-1:0] k);
        return w[k*CORNER_W +: CORNER_W];
    endfunction

    // Corner count of a face word: 3 or 4 when valid, 0 when invalid.
    function automatic logic [2:0] face_corners(input logic [FACE_W-1:0] w);
        logic [CORNER_W-1:0] c0;
        logic [CORNER_W-1:0] c1;
        logic [CORNER_W-1:0] c2;
        logic [CORNER_W-1:0] c3;
        logic [CORNER_W-1:0] lim;
        logic [2:0]          n;
        c0  = w[0*CORNER_W +: CORNER_W];
        c1  = w[1*CORNER_W +: CORNER_W];
        c2  = w[2*CORNER_W +: CORNER_W];
        c3  = w[3*CORNER_W +: CORNER_W];
        lim = CORNER_W'(MAX_VERTS);
        n   = 3'd0;
        if (c0 >= ABSENT_CORNER || c1 >= ABSENT_CORNER || c2 >= ABSENT_CORNER) begin
            n = 3'd0;
        end else if (c0 >= lim || c1 >= lim || c2 >= lim) begin
            n = 3'd0;
        end else if (c3 >= ABSENT_CORNER) begin
            n = (c0 == c1 || c1 == c2 || c2 == c0) ? 3'd0 : 3'd3;
        end else if (c3 >= lim) begin
            n = 3'd0;
        end else begin
            n = (c0 == c1 || c1 == c2 || c2 == c3 || c3 == c0) ? 3'd0 : 3'd4;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mesh_edge_adjacency_scan_top.sv =====
// The block takes one word at a time; the shared 27x27 MAC unit, with up to 25
// steps per edge test, sets the scan time.
// Reset: synchronous, active low; clears control state and loads the register
// defaults. Vertex and face tables are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module mesh_edge_adjacency_scan_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [adjs_pkg::OP_W-1:0]             i_op,
    input  wire logic [adjs_pkg::SLOT_W-1:0]           i_slot,
    input  wire logic signed [adjs_pkg::COORD_W-1:0]   i_coord_x,
    input  wire logic signed [adjs_pkg::COORD_W-1:0]   i_coord_y,
    input  wire logic signed [adjs_pkg::COORD_W-1:0]   i_coord_z,
    input  wire logic [adjs_pkg::CORNER_W-1:0]         i_corner0,
    input  wire logic [adjs_pkg::CORNER_W-1:0]         i_corner1,
    input  wire logic [adjs_pkg::CORNER_W-1:0]         i_corner2,
    input  wire logic [adjs_pkg::CORNER_W-1:0]         i_corner3,
    input  wire logic [adjs_pkg::EDGE_W-1:0]           i_edge_number,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_found,
    output logic [adjs_pkg::OFACE_W-1:0]               o_other_face,
    output logic [adjs_pkg::EDGE_W-1:0]                o_other_edge,
    output logic                                       o_last,
    input  wire logic                                  i_cfg_we,
    input  wire logic [adjs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [adjs_pkg::EPS_W-1:0]            i_cfg_data
);
    import adjs_pkg::*;

    // Configuration registers. Users write them only while idle; not enforced.
    logic [CNT_W-1:0] r_face_count;
    logic [EPS_W-1:0] r_dist_eps;
    logic [EPS_W-1:0] r_edge_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_count <= '0;
            r_dist_eps   <= EPS_W'(16);
            r_edge_eps   <= EPS_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FACE_COUNT: r_face_count <= i_cfg_data[CNT_W-1:0];
                CFG_DIST_EPS:   r_dist_eps   <= i_cfg_data;
                CFG_EDGE_EPS:   r_edge_eps   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                vtx_we;
    logic                face_we;
    logic [VADDR_W-1:0]  vtx_raddr;
    logic [VTX_W-1:0]    vtx_rdata;
    logic [FADDR_W-1:0]  face_raddr;
    logic [FACE_W-1:0]   face_rdata;
    t_mac_req            w_mac_req;
    t_mac_rsp            w_mac_rsp;

    // Vertex table: one word per vertex, packed z, y, x from the top bits down.
    adjs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTS)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (i_slot[VADDR_W-1:0]),
        .i_wdata ({i_coord_z, i_coord_y, i_coord_x}),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    // Face table: four 7-bit corner indices per face, corner 0 in the low bits.
    adjs_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_face_ram (
        .i_clk   (i_clk),
        .i_we    (face_we),
        .i_waddr (i_slot[FADDR_W-1:0]),
        .i_wdata ({i_corner3, i_corner2, i_corner1, i_corner0}),
        .i_raddr (face_raddr),
        .o_rdata (face_rdata)
    );

    // The single multiply-accumulate unit that every test product runs through.
    adjs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .o_rsp   (w_mac_rsp)
    );

    // The sequencer walks the later faces and edges and holds the result
    // register, so a finished word can wait while the next item is taken.
    adjs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_slot        (i_slot),
        .i_edge_number (i_edge_number),
        .i_face_count  (r_face_count),
        .i_dist_eps    (r_dist_eps),
        .i_edge_eps    (r_edge_eps),
        .o_vtx_we      (vtx_we),
        .o_face_we     (face_we),
        .o_vtx_raddr   (vtx_raddr),
        .i_vtx_rdata   (vtx_rdata),
        .o_face_raddr  (face_raddr),
        .i_face_rdata  (face_rdata),
        .o_mac_req     (w_mac_req),
        .i_mac_rsp     (w_mac_rsp),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_other_face  (o_other_face),
        .o_other_edge  (o_other_edge),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // A new MAC run is only launched once the previous one has finished.
    a_mac_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_req.start |-> !w_mac_rsp.busy)
        else $error("MAC started while busy");

    // Completion of a MAC run always follows a busy cycle.
    a_mac_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_rsp.done |-> $past(w_mac_rsp.busy))
        else $error("MAC done without a run");

    // The block takes no new word while a test product is in flight.
    a_ready_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_mac_rsp.busy)
        else $error("input ready during a MAC run");
`endif

endmodule

`default_nettype wire

// ===== sv/adjs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module adjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/adjs_mac.sv =====
// Shared multiply-accumulate unit: one 27x27 partial product per cycle during a run.
// Depends on adjs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adjs_mac (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire adjs_pkg::t_mac_req i_req,
    output adjs_pkg::t_mac_rsp     o_rsp
);
    import adjs_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [2:0]              r_cnt;
    logic [MAG_W-1:0]        r_a;
    logic [MAG_W-1:0]        r_b;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_pp;
    logic [1:0]              r_sh;
    logic signed [ACC_W-1:0] r_acc;

    logic [HALF_W-1:0]       w_ap;
    logic [HALF_W-1:0]       w_bp;
    logic [MAG_W-1:0]        n_pp;
    logic [1:0]              n_sh;
    logic signed [ACC_W-1:0] w_term;

    // Partial k pairs half k[1] of a with half k[0] of b.
    always_comb begin
        w_ap   = r_cnt[1] ? r_a[MAG_W-1:HALF_W] : r_a[HALF_W-1:0];
        w_bp   = r_cnt[0] ? r_b[MAG_W-1:HALF_W] : r_b[HALF_W-1:0];
        n_pp   = MAG_W'(w_ap) * MAG_W'(w_bp);
        n_sh   = 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
        case (r_sh)
            2'd0:    w_term = ACC_W'(r_pp);
            2'd1:    w_term = ACC_W'(r_pp) << HALF_W;
            default: w_term = ACC_W'(r_pp) << (2 * HALF_W);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(MAC_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_neg <= i_req.neg;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_cnt != 3'(MAC_STEPS)) begin
                r_pp <= n_pp;
                r_sh <= n_sh;
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_neg ? (r_acc - w_term) : (r_acc + w_term);
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.acc  = r_acc;

endmodule

`default_nettype wire

// ===== sv/adjs_seq.sv =====
// Sequencer of the edge adjacency scan: table access, test micro-program on
// the shared MAC unit, and result words. Depends on adjs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adjs_seq (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [adjs_pkg::OP_W-1:0]              i_op,
    input  wire logic [adjs_pkg::SLOT_W-1:0]            i_slot,
    input  wire logic [adjs_pkg::EDGE_W-1:0]            i_edge_number,
    input  wire logic [adjs_pkg::CNT_W-1:0]             i_face_count,
    input  wire logic [adjs_pkg::EPS_W-1:0]             i_dist_eps,
    input  wire logic [adjs_pkg::EPS_W-1:0]             i_edge_eps,
    output logic                                        o_vtx_we,
    output logic                                        o_face_we,
    output logic [adjs_pkg::VADDR_W-1:0]                o_vtx_raddr,
    input  wire logic [adjs_pkg::VTX_W-1:0]             i_vtx_rdata,
    output logic [adjs_pkg::FADDR_W-1:0]                o_face_raddr,
    input  wire logic [adjs_pkg::FACE_W-1:0]            i_face_rdata,
    output adjs_pkg::t_mac_req                          o_mac_req,
    input  wire adjs_pkg::t_mac_rsp                     i_mac_rsp,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic                                        o_found,
    output logic [adjs_pkg::OFACE_W-1:0]                o_other_face,
    output logic [adjs_pkg::EDGE_W-1:0]                 o_other_edge,
    output logic                                        o_last
);
    import adjs_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_FA    = 17'h00002,
        S_FA_D  = 17'h00004,
        S_VA0   = 17'h00008,
        S_VA1   = 17'h00010,
        S_VA1_D = 17'h00020,
        S_FB    = 17'h00040,
        S_FB_D  = 17'h00080,
        S_VB0   = 17'h00100,
        S_VB1   = 17'h00200,
        S_VB1_D = 17'h00400,
        S_ISSUE = 17'h00800,
        S_WAIT  = 17'h01000,
        S_NEXT  = 17'h02000,
        S_HIT   = 17'h04000,
        S_DONE  = 17'h08000,
        S_SPARE = 17'h10000
    } t_state;

    // Micro-program steps: ST_TEST opens a test, the rest end in an action.
    localparam logic [4:0] ST_LEN2   = 5'd2;
    localparam logic [4:0] ST_DE2    = 5'd3;
    localparam logic [4:0] ST_EE2    = 5'd4;
    localparam logic [4:0] ST_TEST   = 5'd5;
    localparam logic [4:0] ST_DIR    = 5'd7;
    localparam logic [4:0] ST_PP0    = 5'd10;
    localparam logic [4:0] ST_AP0    = 5'd13;
    localparam logic [4:0] ST_DIST0  = 5'd16;
    localparam logic [4:0] ST_PP1    = 5'd19;
    localparam logic [4:0] ST_AP1    = 5'd22;
    localparam logic [4:0] ST_DIST1  = 5'd25;
    localparam logic [4:0] ST_START  = 5'd27;
    localparam logic [4:0] ST_LAST   = 5'd29;

    t_state r_state;
    t_state n_state;

    logic [4:0]                r_step;
    logic [EDGE_W-1:0]         r_edge;
    logic [FADDR_W-1:0]        r_fa;
    logic [CNT_W-1:0]          r_limit;
    logic [CNT_W-1:0]          r_f2;
    logic [EDGE_W-1:0]         r_e2;
    logic [FACE_W-1:0]         r_fcorn;
    logic [2:0]                r_n;
    logic signed [COORD_W-1:0] r_a0 [3];
    logic signed [COORD_W-1:0] r_b0 [3];
    logic signed [VEC_W-1:0]   r_da [3];
    logic signed [VEC_W-1:0]   r_db [3];
    logic signed [VEC_W-1:0]   r_p0 [3];
    logic signed [VEC_W-1:0]   r_p1 [3];
    logic signed [OPND_W-1:0]  r_len2;
    logic signed [OPND_W-1:0]  r_de2;
    logic signed [OPND_W-1:0]  r_ee2;
    logic signed [OPND_W-1:0]  r_pp;
    logic signed [OPND_W-1:0]  r_ap0;
    logic signed [OPND_W-1:0]  r_ap1;
    logic signed [OPND_W-1:0]  r_r;
    logic                      r_pend;
    logic [OFACE_W-1:0]        r_pend_face;
    logic [EDGE_W-1:0]         r_pend_edge;
    logic                      r_out_valid;
    logic                      r_found;
    logic [OFACE_W-1:0]        r_other_face;
    logic [EDGE_W-1:0]         r_other_edge;
    logic                      r_last;

    logic                      w_accept;
    logic [CNT_W-1:0]          w_limit;
    logic [2:0]                w_nfa;
    logic [2:0]                w_nfb;
    logic [EDGE_W-1:0]         w_enext;
    logic [EDGE_W-1:0]         w_e2next;
    logic signed [OPND_W-1:0]  w_x;
    logic signed [OPND_W-1:0]  w_y;
    logic signed [OPND_W-1:0]  w_xm;
    logic signed [OPND_W-1:0]  w_ym;
    logic                      w_sub;
    logic                      w_clr;
    logic signed [OPND_W-1:0]  w_acc_lo;
    logic signed [OPND_W-1:0]  w_rdiff;
    logic                      w_acc_neg;
    logic                      w_acc_pos;
    logic                      w_reject;
    logic                      w_out_free;
    logic                      w_e2_end;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_limit    = (i_face_count > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES) : i_face_count;
    assign w_nfa      = face_corners(i_face_rdata);
    assign w_nfb      = w_nfa;
    assign w_enext    = (({1'b0, r_edge} + 3'd1) == r_n) ? '0 : r_edge + EDGE_W'(1);
    assign w_e2next   = (({1'b0, r_e2} + 3'd1) == r_n) ? '0 : r_e2 + EDGE_W'(1);
    assign w_e2_end   = ({1'b0, r_e2} + 3'd1) == r_n;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_acc_lo   = i_mac_rsp.acc[OPND_W-1:0];
    assign w_rdiff    = r_len2 - w_acc_lo;
    assign w_acc_neg  = i_mac_rsp.acc[ACC_W-1];
    assign w_acc_pos  = !w_acc_neg && (i_mac_rsp.acc != '0);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_vtx_we   = w_accept && (i_op == OP_VERTEX) && ({1'b0, i_slot} < 7'(MAX_VERTS));
    assign o_face_we  = w_accept && (i_op == OP_FACE) && ({1'b0, i_slot} < 7'(MAX_FACES));

    // Table read addresses follow the state.
    always_comb begin
        o_face_raddr = r_fa;
        o_vtx_raddr  = corner_at(r_fcorn, r_edge)[VADDR_W-1:0];
        unique case (r_state)
            S_FB:    o_face_raddr = r_f2[FADDR_W-1:0];
            S_VA1:   o_vtx_raddr  = corner_at(r_fcorn, w_enext)[VADDR_W-1:0];
            S_VB0:   o_vtx_raddr  = corner_at(r_fcorn, r_e2)[VADDR_W-1:0];
            S_VB1:   o_vtx_raddr  = corner_at(r_fcorn, w_e2next)[VADDR_W-1:0];
            default: ;
        endcase
    end

    // Operand table of the test micro-program.
    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_sub = 1'b0;
        w_clr = 1'b0;
        unique case (r_step)
            5'd0:  begin w_x = OPND_W'(r_da[0]); w_y = OPND_W'(r_da[0]); w_clr = 1'b1; end
            5'd1:  begin w_x = OPND_W'(r_da[1]); w_y = OPND_W'(r_da[1]); end
            5'd2:  begin w_x = OPND_W'(r_da[2]); w_y = OPND_W'(r_da[2]); end
            5'd3:  begin w_x = OPND_W'(i_dist_eps); w_y = OPND_W'(i_dist_eps); w_clr = 1'b1; end
            5'd4:  begin w_x = OPND_W'(i_edge_eps); w_y = OPND_W'(i_edge_eps); w_clr = 1'b1; end
            5'd5:  begin w_x = OPND_W'(r_da[0]); w_y = OPND_W'(r_db[0]); w_clr = 1'b1; end
            5'd6:  begin w_x = OPND_W'(r_da[1]); w_y = OPND_W'(r_db[1]); end
            5'd7:  begin w_x = OPND_W'(r_da[2]); w_y = OPND_W'(r_db[2]); end
            5'd8:  begin w_x = OPND_W'(r_p0[0]); w_y = OPND_W'(r_p0[0]); w_clr = 1'b1; end
            5'd9:  begin w_x = OPND_W'(r_p0[1]); w_y = OPND_W'(r_p0[1]); end
            5'd10: begin w_x = OPND_W'(r_p0[2]); w_y = OPND_W'(r_p0[2]); end
            5'd11: begin w_x = OPND_W'(r_da[0]); w_y = OPND_W'(r_p0[0]); w_clr = 1'b1; end
            5'd12: begin w_x = OPND_W'(r_da[1]); w_y = OPND_W'(r_p0[1]); end
            5'd13: begin w_x = OPND_W'(r_da[2]); w_y = OPND_W'(r_p0[2]); end
            5'd14: begin w_x = r_de2; w_y = r_len2; w_clr = 1'b1; end
            5'd15: begin w_x = r_ap0; w_y = r_ap0; end
            5'd16: begin w_x = r_pp;  w_y = r_len2; w_sub = 1'b1; end
            5'd17: begin w_x = OPND_W'(r_p1[0]); w_y = OPND_W'(r_p1[0]); w_clr = 1'b1; end
            5'd18: begin w_x = OPND_W'(r_p1[1]); w_y = OPND_W'(r_p1[1]); end
            5'd19: begin w_x = OPND_W'(r_p1[2]); w_y = OPND_W'(r_p1[2]); end
            5'd20: begin w_x = OPND_W'(r_da[0]); w_y = OPND_W'(r_p1[0]); w_clr = 1'b1; end
            5'd21: begin w_x = OPND_W'(r_da[1]); w_y = OPND_W'(r_p1[1]); end
            5'd22: begin w_x = OPND_W'(r_da[2]); w_y = OPND_W'(r_p1[2]); end
            5'd23: begin w_x = r_de2; w_y = r_len2; w_clr = 1'b1; end
            5'd24: begin w_x = r_ap1; w_y = r_ap1; end
            5'd25: begin w_x = r_pp;  w_y = r_len2; w_sub = 1'b1; end
            5'd26: begin w_x = r_ee2; w_y = r_len2; w_clr = 1'b1; end
            5'd27: begin w_x = r_ap0; w_y = r_ap0; w_sub = 1'b1; end
            5'd28: begin w_x = r_ee2; w_y = r_len2; w_clr = 1'b1; end
            5'd29: begin w_x = r_r;   w_y = r_r;   w_sub = 1'b1; end
            default: ;
        endcase
        w_xm = w_x[OPND_W-1] ? -w_x : w_x;
        w_ym = w_y[OPND_W-1] ? -w_y : w_y;
    end

    assign o_mac_req.start = (r_state == S_ISSUE);
    assign o_mac_req.clr   = w_clr;
    assign o_mac_req.neg   = w_x[OPND_W-1] ^ w_y[OPND_W-1] ^ w_sub;
    assign o_mac_req.a     = w_xm[MAG_W-1:0];
    assign o_mac_req.b     = w_ym[MAG_W-1:0];

    // Early-out tests at the end of selected steps.
    always_comb begin
        case (r_step)
            ST_DIR:   w_reject = !w_acc_neg;
            ST_AP0:   w_reject = w_acc_neg;
            ST_DIST0: w_reject = w_acc_neg;
            ST_AP1:   w_reject = w_rdiff[OPND_W-1];
            ST_DIST1: w_reject = w_acc_neg;
            ST_START: w_reject = w_acc_pos;
            ST_LAST:  w_reject = w_acc_pos;
            default:  w_reject = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_op == OP_SCAN) begin
                    n_state = (i_slot < SLOT_W'(w_limit)) ? S_FA : S_DONE;
                end
            end
            S_FA:    n_state = S_FA_D;
            S_FA_D:  n_state = (w_nfa == 3'd0 || {1'b0, r_edge} >= w_nfa) ? S_DONE : S_VA0;
            S_VA0:   n_state = S_VA1;
            S_VA1:   n_state = S_VA1_D;
            S_VA1_D: n_state = S_ISSUE;
            S_FB:    n_state = (r_f2 >= r_limit) ? S_DONE : S_FB_D;
            S_FB_D:  n_state = (w_nfb == 3'd0) ? S_FB : S_VB0;
            S_VB0:   n_state = S_VB1;
            S_VB1:   n_state = S_VB1_D;
            S_VB1_D: n_state = S_ISSUE;
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (i_mac_rsp.done) begin
                    if (r_step == ST_LAST) begin
                        n_state = w_reject ? S_NEXT : S_HIT;
                    end else if (w_reject) begin
                        n_state = S_NEXT;
                    end else if (r_step == ST_EE2) begin
                        n_state = S_FB;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_NEXT:  n_state = w_e2_end ? S_FB : S_VB0;
            S_HIT:   n_state = (!r_pend || w_out_free) ? S_NEXT : S_HIT;
            S_DONE:  n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_HIT) begin
                if (!r_pend) begin
                    r_pend <= 1'b1;
                end else if (w_out_free) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_edge  <= i_edge_number;
                r_fa    <= i_slot[FADDR_W-1:0];
                r_limit <= w_limit;
                r_f2    <= i_slot[CNT_W-1:0] + CNT_W'(1);
                r_step  <= '0;
            end
            S_FA_D: begin
                r_fcorn <= i_face_rdata;
                r_n     <= w_nfa;
            end
            S_VA1: begin
                for (int k = 0; k < 3; k++) begin
                    r_a0[k] <= i_vtx_rdata[k*COORD_W +: COORD_W];
                end
            end
            S_VA1_D: begin
                for (int k = 0; k < 3; k++) begin
                    r_da[k] <= VEC_W'(signed'(i_vtx_rdata[k*COORD_W +: COORD_W]))
                             - VEC_W'(r_a0[k]);
                end
            end
            S_FB: ;
            S_FB_D: begin
                r_fcorn <= i_face_rdata;
                r_n     <= w_nfb;
                r_e2    <= '0;
                if (w_nfb == 3'd0) begin
                    r_f2 <= r_f2 + CNT_W'(1);
                end
            end
            S_VB1: begin
                for (int k = 0; k < 3; k++) begin
                    r_b0[k] <= i_vtx_rdata[k*COORD_W +: COORD_W];
                end
            end
            S_VB1_D: begin
                r_step <= ST_TEST;
                for (int k = 0; k < 3; k++) begin
                    r_db[k] <= VEC_W'(signed'(i_vtx_rdata[k*COORD_W +: COORD_W]))
                             - VEC_W'(r_b0[k]);
                    r_p0[k] <= VEC_W'(r_b0[k]) - VEC_W'(r_a0[k]);
                    r_p1[k] <= VEC_W'(signed'(i_vtx_rdata[k*COORD_W +: COORD_W]))
                             - VEC_W'(r_a0[k]);
                end
            end
            S_WAIT: begin
                if (i_mac_rsp.done) begin
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        ST_LEN2: r_len2 <= w_acc_lo;
                        ST_DE2:  r_de2  <= w_acc_lo;
                        ST_EE2:  r_ee2  <= w_acc_lo;
                        ST_PP0:  r_pp   <= w_acc_lo;
                        ST_AP0:  r_ap0  <= w_acc_lo;
                        ST_PP1:  r_pp   <= w_acc_lo;
                        ST_AP1: begin
                            r_ap1 <= w_acc_lo;
                            r_r   <= w_rdiff;
                        end
                        default: ;
                    endcase
                end
            end
            S_NEXT: begin
                if (w_e2_end) begin
                    r_f2 <= r_f2 + CNT_W'(1);
                end else begin
                    r_e2 <= r_e2 + EDGE_W'(1);
                end
            end
            S_HIT: begin
                if (!r_pend || w_out_free) begin
                    r_pend_face <= r_f2[OFACE_W-1:0];
                    r_pend_edge <= r_e2;
                end
                if (r_pend && w_out_free) begin
                    r_found      <= 1'b1;
                    r_other_face <= r_pend_face;
                    r_other_edge <= r_pend_edge;
                    r_last       <= 1'b0;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_found      <= r_pend;
                    r_other_face <= r_pend ? r_pend_face : '0;
                    r_other_edge <= r_pend ? r_pend_edge : '0;
                    r_last       <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_other_face = r_other_face;
    assign o_other_edge = r_other_edge;
    assign o_last       = r_last;

endmodule

`default_nettype wire
